// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl of the indexed sequence store
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/isq_pkg.sv =====
// shared types and codes for the indexed sequence store
// no dependencies
package isq_pkg;

  // field widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 11;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 11;

  // default number of entries
  localparam int DEF_CAPACITY = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ      = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/isq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module isq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/indexed_sequence_store.sv =====
// top level of the indexed sequence store: sequencer, count and result beat
// depends on isq_pkg, isq_ram and assert_macros.svh
//
// channel   direction  handshake          payload
// request   in         start, busy        op_i, position_i, data_value_i
// result    out        done_o (strobe)    read_value_o, hit_o, status_o, element_count_o
//
// a rejected or trivial request (out of range, full, unused op, append at the end,
// delete of the last entry) gives its result beat on the edge after acceptance
// a read does one ram read, then gives the result beat
// a shifting insert moves entries up, top first, and a shifting delete moves them down,
// bottom first; the single ram moves one entry a cycle, read then write-back
// reset clears state, count, done and hit only; the entry store needs no clearing pass
// the result beat cannot be stalled; a new request may be taken in the same cycle
`include "assert_macros.svh"

module indexed_sequence_store #(
  parameter int CAPACITY = isq_pkg::DEF_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [isq_pkg::OP_W-1:0]            op_i,
  input  logic [isq_pkg::POS_W-1:0]           position_i,
  input  logic signed [isq_pkg::DATA_W-1:0]   data_value_i,
  output logic                                done_o,
  output logic signed [isq_pkg::DATA_W-1:0]   read_value_o,
  output logic                                hit_o,
  output logic [isq_pkg::STATUS_W-1:0]        status_o,
  output logic [isq_pkg::COUNT_W-1:0]         element_count_o
);

  import isq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_OPEN   = 3'd2;
  localparam logic [2:0] S_CLOSE  = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       wr_q, wr_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic                done_q, done_d;
  logic                hit_q, hit_d;
  logic [DATA_W-1:0]   rv_q, rv_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [XW-1:0]       pos_x, cnt_x;
  logic [CW-1:0]       pos_c, pos_p1, cnt_m1, cnt_m2, wr_m1, wr_m2, wr_p1, wr_p2, pos_q_p1;
  logic [CW-1:0]       ins_pos;
  logic                ins_go;
  logic                full;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  // position and count on a common width
  assign pos_x    = XW'(position_i);
  assign cnt_x    = XW'(cnt_q);
  assign pos_c    = pos_x[CW-1:0];
  assign pos_p1   = pos_c + ONE_C;
  assign cnt_m1   = cnt_q - ONE_C;
  assign cnt_m2   = cnt_q - TWO_C;
  assign wr_m1    = wr_q - ONE_C;
  assign wr_m2    = wr_q - TWO_C;
  assign wr_p1    = wr_q + ONE_C;
  assign wr_p2    = wr_q + TWO_C;
  assign pos_q_p1 = pos_q + ONE_C;
  assign full     = (cnt_q == CAP_C);

  // request decode and shift sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    wr_d      = wr_q;
    val_d     = val_q;
    done_d    = 1'b0;
    hit_d     = 1'b0;
    rv_d      = '1;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ins_go    = 1'b0;
    ins_pos   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op_i)
            OP_READ: begin
              if (pos_x < cnt_x) begin
                ram_re    = 1'b1;
                ram_raddr = pos_c[AW-1:0];
                state_d   = S_RDWAIT;
              end else begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end
            end
            OP_INS_FRONT: begin
              ins_go  = 1'b1;
              ins_pos = '0;
            end
            OP_INS_BACK: begin
              ins_go  = 1'b1;
              ins_pos = cnt_q;
            end
            OP_INS_POS: begin
              if (pos_x > cnt_x) begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end else begin
                ins_go  = 1'b1;
                ins_pos = pos_c;
              end
            end
            OP_DELETE: begin
              if (pos_x >= cnt_x) begin
                done_d   = 1'b1;
                status_d = ST_RANGE;
              end else if (pos_c == cnt_m1) begin
                cnt_d    = cnt_m1;
                done_d   = 1'b1;
                status_d = ST_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_p1[AW-1:0];
                wr_d      = pos_c;
                state_d   = S_CLOSE;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_RANGE;
            end
          endcase

          // common insert path
          if (ins_go) begin
            if (full) begin
              done_d   = 1'b1;
              status_d = ST_FULL;
            end else if (ins_pos == cnt_q) begin
              ram_we    = 1'b1;
              ram_waddr = ins_pos[AW-1:0];
              ram_wdata = data_value_i;
              cnt_d     = cnt_q + ONE_C;
              done_d    = 1'b1;
              status_d  = ST_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[AW-1:0];
              wr_d      = cnt_q;
              pos_d     = ins_pos;
              val_d     = data_value_i;
              state_d   = S_OPEN;
            end
          end
        end
      end

      S_RDWAIT: begin
        rv_d     = ram_rdata;
        hit_d    = 1'b1;
        status_d = ST_DONE;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      // move entries up by one, top first
      S_OPEN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (wr_q == pos_q_p1) begin
          state_d = S_INS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wr_m2[AW-1:0];
          wr_d      = wr_m1;
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = val_q;
        cnt_d     = cnt_q + ONE_C;
        done_d    = 1'b1;
        status_d  = ST_DONE;
        state_d   = S_IDLE;
      end

      // move entries down by one, bottom first
      S_CLOSE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (wr_q == cnt_m2) begin
          cnt_d    = cnt_m1;
          done_d   = 1'b1;
          status_d = ST_DONE;
          state_d  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wr_p2[AW-1:0];
          wr_d      = wr_p1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    wr_q     <= wr_d;
    val_q    <= val_d;
    rv_q     <= rv_d;
    status_q <= status_d;
  end

  // entry store
  isq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result beat
  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign read_value_o    = rv_q;
  assign hit_o           = hit_q;
  assign status_o        = status_q;
  assign element_count_o = cnt_x[COUNT_W-1:0];

  // checks
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_ALWAYS(a_cnt_cap, clk_i, rst_ni, cnt_q <= CAP_C)
  `ASSERT_IMPL(a_hit_done, clk_i, rst_ni, hit_o, done_o && (status_o == ST_DONE))
  `ASSERT_NEXT(a_cnt_hold, clk_i, rst_ni, !busy && !start, $stable(cnt_q))

endmodule
